// ===== hdl/acng_pkg.sv =====
// Shared types and constants of the audio compressor with noise gate.
// Holds the word formats, the register map, the job format and the sequencer states.
// No dependencies.
package acng_pkg;

    // Fixed-point format of the envelopes and the sample width.
    localparam int FRACTION_BITS = 24;
    localparam int SAMPLE_BITS   = 16;
    localparam int LEVEL_W       = 15;
    localparam int DECAY_W       = 24;
    localparam int GAIN_W        = 10;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_INDEX_W   = 3;

    localparam int PEAK_W    = SAMPLE_BITS + FRACTION_BITS;
    localparam int GATE_W    = LEVEL_W + FRACTION_BITS;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DRIVE_W   = SAMPLE_BITS + GAIN_W;
    localparam int MT_W      = SAMPLE_BITS + LEVEL_W;
    localparam int NUM_W     = MT_W + GATE_W;
    localparam int DEN_SPLIT = PEAK_W / 2;
    localparam int DEN_W     = PEAK_W + LEVEL_W;
    localparam int DIV_STEPS = SAMPLE_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Register map.
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_DECAY  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GATE_DECAY  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_FLOOR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GATE_GAIN   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_GATE_LIMIT  = 3'd6;

    // Reset values of the registers.
    localparam logic [DECAY_W-1:0] RST_PEAK_DECAY = 24'd16776880;
    localparam logic [DECAY_W-1:0] RST_GATE_DECAY = 24'd16775538;
    localparam logic [LEVEL_W-1:0] RST_PEAK_FLOOR = 15'd512;
    localparam logic [LEVEL_W-1:0] RST_TARGET     = 15'd30000;
    localparam logic [GAIN_W-1:0]  RST_GATE_GAIN  = 10'd100;
    localparam logic [LEVEL_W-1:0] RST_GATE_LIMIT = 15'd32767;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          last_in_block;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last_out;
    } out_word_t;

    typedef struct packed {
        logic               compressor_enable;
        logic [DECAY_W-1:0] peak_decay;
        logic [DECAY_W-1:0] gate_decay;
        logic [LEVEL_W-1:0] peak_floor;
        logic [LEVEL_W-1:0] target_level;
        logic [GAIN_W-1:0]  gate_gain;
        logic [LEVEL_W-1:0] gate_limit;
    } cfg_t;

    // A classified sample as it travels from the front end to the back end.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [SAMPLE_BITS-1:0] mag;
        logic                   neg;
        logic                   last;
        logic                   bypass;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_PD_HI,
        BK_PD_LO,
        BK_GD_HI,
        BK_GD_LO,
        BK_DRIVE,
        BK_MT,
        BK_NUM_LO,
        BK_NUM_HI,
        BK_DEN_LO,
        BK_DEN_HI,
        BK_CHECK,
        BK_CMP,
        BK_DIV,
        BK_DONE
    } bk_state_t;

endpackage

// ===== hdl/acng_front.sv =====
// Front end of the compressor: accepts input words and classifies them.
// Rectifies the sample and marks words that bypass processing.
// Depends on acng_pkg.
module acng_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  logic               in_valid,
    output logic               in_ready,
    input  acng_pkg::in_word_t in_word,
    output logic               job_valid,
    input  logic               job_ready,
    output acng_pkg::job_t     job
);
    import acng_pkg::*;

    logic                   valid_reg;
    job_t                   job_reg;
    job_t                   job_next;
    logic [SAMPLE_BITS-1:0] raw;

    assign raw = in_word.sample_in;

    always_comb
    begin
        job_next.sample = raw;
        job_next.neg    = raw[SAMPLE_BITS-1];
        job_next.mag    = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
        job_next.last   = in_word.last_in_block;
        job_next.bypass = ~enable;
    end

    assign in_ready  = ~valid_reg | job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== hdl/acng_queue.sv =====
// Short job queue between the front end and the back end.
// A small circular buffer of classified samples.
// Depends on acng_pkg.
module acng_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  acng_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output acng_pkg::job_t pop_job
);
    import acng_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    job_t               mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != COUNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/acng_back.sv =====
// Back end of the compressor: envelope update, gain product and serial divider.
// One shared 32x32 multiplier is stepped by a sequencer; the quotient is formed bit by bit.
// Depends on acng_pkg.
module acng_back (
    input  logic                clk,
    input  logic                rst_n,
    input  acng_pkg::cfg_t      cfg,
    input  logic                job_valid,
    output logic                job_ready,
    input  acng_pkg::job_t      job,
    output logic                out_valid,
    input  logic                out_ready,
    output acng_pkg::out_word_t out_word
);
    import acng_pkg::*;

    bk_state_t              state_reg;
    bk_state_t              state_next;

    logic [PEAK_W-1:0]      peak_reg;
    logic [GATE_W-1:0]      gate_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PEAK_W-1:0]      acc_reg;
    logic [MT_W-1:0]        mt_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [DEN_W-1:0]       rem_reg;
    logic [DIV_STEPS-1:0]   q_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   sat_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic                   neg_reg;
    logic                   last_reg;
    logic                   out_valid_reg;
    out_word_t              out_word_reg;

    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [LEVEL_W-1:0]     floor_v;
    logic [LEVEL_W-1:0]     limit_v;
    logic [PEAK_W-1:0]      pdec;
    logic [PEAK_W-1:0]      mag_sh;
    logic [PEAK_W-1:0]      floor_sh;
    logic [PEAK_W-1:0]      peak_new;
    logic [DRIVE_W-1:0]     drive;
    logic [LEVEL_W-1:0]     drive_c;
    logic [GATE_W-1:0]      drive_sh;
    logic                   overflow;
    logic [DEN_W:0]         trial;
    logic                   trial_ge;
    logic [DIV_STEPS-1:0]   q_lim;
    logic [DIV_STEPS-1:0]   q_clip;
    logic [SAMPLE_BITS-1:0] result;
    logic                   slot_free;
    logic                   take_job;
    logic                   load_bypass;
    logic                   load_result;

    assign slot_free = ~out_valid_reg | out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A zero floor or limit acts as one.
    assign floor_v = (cfg.peak_floor == '0) ? LEVEL_W'(1) : cfg.peak_floor;
    assign limit_v = (cfg.gate_limit == '0) ? LEVEL_W'(1) : cfg.gate_limit;

    // Shared multiplier operands, chosen by the step being run.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            BK_PD_HI:
            begin
                mul_a = MUL_W'(peak_reg[PEAK_W-1:FRACTION_BITS]);
                mul_b = MUL_W'(cfg.peak_decay);
            end
            BK_PD_LO:
            begin
                mul_a = MUL_W'(peak_reg[FRACTION_BITS-1:0]);
                mul_b = MUL_W'(cfg.peak_decay);
            end
            BK_GD_HI:
            begin
                mul_a = MUL_W'(gate_reg[GATE_W-1:FRACTION_BITS]);
                mul_b = MUL_W'(cfg.gate_decay);
            end
            BK_GD_LO:
            begin
                mul_a = MUL_W'(gate_reg[FRACTION_BITS-1:0]);
                mul_b = MUL_W'(cfg.gate_decay);
            end
            BK_DRIVE:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(cfg.gate_gain);
            end
            BK_MT:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(cfg.target_level);
            end
            BK_NUM_LO:
            begin
                mul_a = MUL_W'(prod_reg[MT_W-1:0]);
                mul_b = MUL_W'(gate_reg[FRACTION_BITS-1:0]);
            end
            BK_NUM_HI:
            begin
                mul_a = MUL_W'(mt_reg);
                mul_b = MUL_W'(gate_reg[GATE_W-1:FRACTION_BITS]);
            end
            BK_DEN_LO:
            begin
                mul_a = MUL_W'(peak_reg[DEN_SPLIT-1:0]);
                mul_b = MUL_W'(limit_v);
            end
            BK_DEN_HI:
            begin
                mul_a = MUL_W'(peak_reg[PEAK_W-1:DEN_SPLIT]);
                mul_b = MUL_W'(limit_v);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Peak envelope: largest of the decayed peak, the magnitude and the floor.
    assign pdec     = acc_reg + PEAK_W'(prod_reg[2*FRACTION_BITS-1:FRACTION_BITS]);
    assign mag_sh   = {mag_reg, {FRACTION_BITS{1'b0}}};
    assign floor_sh = PEAK_W'({floor_v, {FRACTION_BITS{1'b0}}});

    always_comb
    begin
        peak_new = pdec;
        if (mag_sh > peak_new)
        begin
            peak_new = mag_sh;
        end
        if (floor_sh > peak_new)
        begin
            peak_new = floor_sh;
        end
    end

    // Gate drive, clamped to the limit.
    assign drive    = prod_reg[DRIVE_W-1:0];
    assign drive_c  = (drive > DRIVE_W'(limit_v)) ? limit_v : drive[LEVEL_W-1:0];
    assign drive_sh = {drive_c, {FRACTION_BITS{1'b0}}};

    // Quotient overflow check and one restoring divide step.
    assign overflow = ({{(DEN_W + DIV_STEPS - NUM_W){1'b0}}, num_reg} >= {den_reg, {DIV_STEPS{1'b0}}});
    assign trial    = {rem_reg, num_reg[DIV_STEPS-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    // Saturate the magnitude and restore the sign.
    assign q_lim  = neg_reg ? DIV_STEPS'(1) << (SAMPLE_BITS - 1)
                            : (DIV_STEPS'(1) << (SAMPLE_BITS - 1)) - 1'b1;
    assign q_clip = (sat_reg || (q_reg > q_lim)) ? q_lim : q_reg;
    assign result = neg_reg ? (~q_clip[SAMPLE_BITS-1:0] + 1'b1) : q_clip[SAMPLE_BITS-1:0];

    always_comb
    begin
        state_next  = state_reg;
        job_ready   = 1'b0;
        take_job    = 1'b0;
        load_bypass = 1'b0;
        load_result = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                job_ready = job.bypass ? slot_free : 1'b1;
                if (job_valid && job_ready)
                begin
                    if (job.bypass)
                    begin
                        load_bypass = 1'b1;
                    end
                    else
                    begin
                        take_job   = 1'b1;
                        state_next = BK_PD_HI;
                    end
                end
            end
            BK_PD_HI:  state_next = BK_PD_LO;
            BK_PD_LO:  state_next = BK_GD_HI;
            BK_GD_HI:  state_next = BK_GD_LO;
            BK_GD_LO:  state_next = BK_DRIVE;
            BK_DRIVE:  state_next = BK_MT;
            BK_MT:     state_next = BK_NUM_LO;
            BK_NUM_LO: state_next = BK_NUM_HI;
            BK_NUM_HI: state_next = BK_DEN_LO;
            BK_DEN_LO: state_next = BK_DEN_HI;
            BK_DEN_HI: state_next = BK_CHECK;
            BK_CHECK:  state_next = BK_CMP;
            BK_CMP:    state_next = overflow ? BK_DONE : BK_DIV;
            BK_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (slot_free)
                begin
                    load_result = 1'b1;
                    state_next  = BK_IDLE;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
            gate_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_bypass || load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == BK_GD_HI)
            begin
                peak_reg <= peak_new;
            end
            if (state_reg == BK_MT)
            begin
                gate_reg <= (drive_sh > acc_reg[GATE_W-1:0]) ? drive_sh : acc_reg[GATE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (take_job)
        begin
            mag_reg  <= job.mag;
            neg_reg  <= job.neg;
            last_reg <= job.last;
        end
        if (load_bypass)
        begin
            out_word_reg.sample_out <= job.sample;
            out_word_reg.last_out   <= job.last;
        end
        else if (load_result)
        begin
            out_word_reg.sample_out <= result;
            out_word_reg.last_out   <= last_reg;
        end
        unique case (state_reg)
            BK_PD_LO:  acc_reg <= prod_reg[PEAK_W-1:0];
            BK_GD_LO:  acc_reg <= prod_reg[PEAK_W-1:0];
            BK_DRIVE:  acc_reg <= acc_reg + PEAK_W'(prod_reg[2*FRACTION_BITS-1:FRACTION_BITS]);
            BK_NUM_LO: mt_reg  <= prod_reg[MT_W-1:0];
            BK_NUM_HI: num_reg <= NUM_W'(prod_reg[MT_W+FRACTION_BITS-1:0]);
            BK_DEN_LO:
            begin
                num_reg <= num_reg
                         + (NUM_W'(prod_reg[MT_W+LEVEL_W-1:0]) << FRACTION_BITS);
            end
            BK_DEN_HI: den_reg <= DEN_W'(prod_reg[DEN_SPLIT+LEVEL_W-1:0]);
            BK_CHECK:
            begin
                den_reg <= den_reg
                         + (DEN_W'(prod_reg[DEN_SPLIT+LEVEL_W-1:0]) << DEN_SPLIT);
            end
            BK_CMP:
            begin
                sat_reg <= overflow;
                rem_reg <= DEN_W'(num_reg[NUM_W-1:DIV_STEPS]);
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            BK_DIV:
            begin
                rem_reg <= trial_ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
                num_reg <= num_reg << 1;
                q_reg   <= {q_reg[DIV_STEPS-2:0], trial_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hdl/audio_compressor_noise_gate.sv =====
// Top level of the peak-envelope audio compressor with noise gate.
// Holds the register file and connects front end, job queue and back end.
// Depends on acng_pkg, acng_front, acng_queue and acng_back.

// Each accepted word carries one signed 16-bit sample. When compression is
// enabled, the block updates a decaying peak envelope and a decaying gate level
// from the sample's magnitude and returns sample * target / peak * gate / limit,
// truncated toward zero and saturated to 16 bits; when it is disabled, the
// sample passes unchanged and both envelopes hold. A processed sample occupies
// the back end through ten products on the single shared 32x32 multiplier
// (envelope decay, gate drive, the gain numerator and the divisor), a step to
// finish the divisor, one overflow check and 17 steps of the bit-serial
// divider, plus a step each to start and to hand over the result. A sample
// whose quotient overflows skips the divider and saturates. The back end takes
// no new sample until it has handed over the last one; a pass-through sample
// goes from idle straight to the output register. The front end and a short
// job queue keep taking words while the back end is busy, and the output
// register holds a finished word until it is taken. Registers are written
// through cfg_write, cfg_index and cfg_data with no read-back. The user must
// write them only while the block is idle; the block does not enforce this.
// Indexes beyond the register list are ignored; no clearing pass after reset.
module audio_compressor_noise_gate #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  acng_pkg::in_word_t                   in_word,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output acng_pkg::out_word_t                  out_word,
    input  logic                                 cfg_write,
    input  logic [acng_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [acng_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import acng_pkg::*;

    cfg_t cfg_reg;
    logic fq_valid;
    logic fq_ready;
    job_t fq_job;
    logic qb_valid;
    logic qb_ready;
    job_t qb_job;

    // Register file. Written values are cut to the width of each register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compressor_enable <= 1'b1;
            cfg_reg.peak_decay        <= RST_PEAK_DECAY;
            cfg_reg.gate_decay        <= RST_GATE_DECAY;
            cfg_reg.peak_floor        <= RST_PEAK_FLOOR;
            cfg_reg.target_level      <= RST_TARGET;
            cfg_reg.gate_gain         <= RST_GATE_GAIN;
            cfg_reg.gate_limit        <= RST_GATE_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ENABLE:     cfg_reg.compressor_enable <= cfg_data[0];
                REG_PEAK_DECAY: cfg_reg.peak_decay        <= cfg_data[DECAY_W-1:0];
                REG_GATE_DECAY: cfg_reg.gate_decay        <= cfg_data[DECAY_W-1:0];
                REG_PEAK_FLOOR: cfg_reg.peak_floor        <= cfg_data[LEVEL_W-1:0];
                REG_TARGET:     cfg_reg.target_level      <= cfg_data[LEVEL_W-1:0];
                REG_GATE_GAIN:  cfg_reg.gate_gain         <= cfg_data[GAIN_W-1:0];
                REG_GATE_LIMIT: cfg_reg.gate_limit        <= cfg_data[LEVEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The front end rectifies each sample and tags it for pass-through when
    // compression is off, so the back end never has to look at the sign bit.
    acng_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (cfg_reg.compressor_enable),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // The queue lets the front end keep accepting while a divide is running.
    acng_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    // The back end owns both envelopes and the output register.
    acng_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

// ===== hdl/acng_chk.sv =====
// Port-level checker for the audio compressor with noise gate, and its bind.
// Watches the handshakes and the reset behavior at the top-level ports.
// Depends on acng_pkg and audio_compressor_noise_gate.
module acng_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input acng_pkg::out_word_t out_word
);
    import acng_pkg::*;

    // A word that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped before it was taken");

    // A word that is not taken keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_word))
        else $error("output word changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after reset");

    // The empty front end takes a word as soon as reset is released.
    a_ready_after_reset: assert property (@(posedge clk)
        $past(!rst_n) && rst_n |-> in_ready)
        else $error("input not ready right after reset");

endmodule

bind audio_compressor_noise_gate acng_chk u_acng_chk (.*);
